// File: design/mpa_pkg.sv
// Shared types and constants for the max pooling with argmax block.
// No dependencies; imported by the interfaces and all modules.

package mpa_pkg;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_POOL_DEF    = 8;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int DIM_W      = 11;  // image size registers and position counters
  localparam int POOL_W     = 4;   // window size registers
  localparam int POS_W      = 10;  // position fields of a result
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_POOL_ROWS    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_POOL_COLS    = CFG_IDX_W'(3);

  // Register reset values
  localparam logic [DIM_W-1:0]  IMAGE_WIDTH_RST  = DIM_W'(28);
  localparam logic [DIM_W-1:0]  IMAGE_HEIGHT_RST = DIM_W'(28);
  localparam logic [POOL_W-1:0] POOL_ROWS_RST    = POOL_W'(2);
  localparam logic [POOL_W-1:0] POOL_COLS_RST    = POOL_W'(2);

  typedef struct packed {
    logic busy;
    logic divisible;
  } chk_status_t;

endpackage

// File: design/mpa_in_if.sv
// Input channel: one feature map sample per item.
// Depends on mpa_pkg for the default sample width.

interface mpa_in_if #(
  parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// File: design/mpa_out_if.sv
// Result channel: one pooled value with its argmax per item.
// Depends on mpa_pkg for widths.

interface mpa_out_if #(
  parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEF
) ();
  logic                             valid;
  logic                             ready;
  logic signed [SAMPLE_BITS-1:0]    max_value;
  logic [mpa_pkg::POS_W-1:0]        max_row;
  logic [mpa_pkg::POS_W-1:0]        max_col;
  logic [mpa_pkg::POS_W-1:0]        out_row;
  logic [mpa_pkg::POS_W-1:0]        out_col;
  logic                             last_of_frame;
  logic                             config_error;

  modport source (output valid, output max_value, output max_row, output max_col,
                  output out_row, output out_col, output last_of_frame,
                  output config_error, input ready);
  modport sink   (input valid, input max_value, input max_row, input max_col,
                  input out_row, input out_col, input last_of_frame,
                  input config_error, output ready);
endinterface

// File: design/mpa_cfg_if.sv
// Configuration write channel: register index and data.
// Depends on mpa_pkg for widths.

interface mpa_cfg_if ();
  logic                            valid;
  logic                            ready;
  logic [mpa_pkg::CFG_IDX_W-1:0]   index;
  logic [mpa_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/max_pool_with_argmax.sv
// Streaming 2-D max pooling with argmax, top level.
// Depends on mpa_pkg, mpa_in_if, mpa_out_if, mpa_cfg_if and mpa_divchk.
//
// Samples arrive in raster order, one per item, and the block accepts one
// item every cycle unless the configuration check or a waiting result holds
// the input off; a result appears in the output register in the cycle after
// the bottom-right sample of its window is taken, and the input keeps flowing
// while that result waits unless the next sample would give a result as well.
// Running maxima of windows in progress live in a one-entry-per-window-column
// memory read one item ahead. A write to one of the four registers restarts
// the frame and holds the input off while two bit-serial remainder units check
// that the map divides evenly into windows. With an unusable configuration
// every sample gives one result flagged config_error with all other fields zero.

module max_pool_with_argmax #(
  parameter int MAX_WIDTH   = mpa_pkg::MAX_WIDTH_DEF,
  parameter int MAX_POOL    = mpa_pkg::MAX_POOL_DEF,
  parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  mpa_in_if.sink    in_ch,
  mpa_out_if.source out_ch,
  mpa_cfg_if.sink   cfg_ch
);
  import mpa_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int PW = $clog2(MAX_POOL);
  localparam int MW = SAMPLE_BITS + 2 * PW;

  // configuration
  logic [DIM_W-1:0]  image_width_r;
  logic [DIM_W-1:0]  image_height_r;
  logic [POOL_W-1:0] pool_rows_r;
  logic [POOL_W-1:0] pool_cols_r;
  logic              cfg_wr;
  logic              cfg_hit;
  logic              chk_start_r;
  chk_status_t       chk_w_st;
  chk_status_t       chk_h_st;
  logic              chk_busy;
  logic              cfg_ok;

  // position
  logic [DIM_W-1:0] cur_row_r, cur_row_nxt;
  logic [DIM_W-1:0] cur_col_r, cur_col_nxt;
  logic [DIM_W-1:0] r0_r, r0_nxt;
  logic [DIM_W-1:0] c0_r, c0_nxt;
  logic [DIM_W-1:0] orow_r, orow_nxt;
  logic [AW-1:0]    wc_r, wc_nxt;
  logic [PW-1:0]    ir_r, ir_nxt;
  logic [PW-1:0]    ic_r, ic_nxt;

  // datapath
  logic [MW-1:0]                 mem [MAX_WIDTH];
  logic [MW-1:0]                 rd_r;
  logic [MW-1:0]                 wr_data;
  logic                          mem_we;
  logic signed [SAMPLE_BITS-1:0] rd_max;
  logic [PW-1:0]                 rd_ar, rd_ac;
  logic signed [SAMPLE_BITS-1:0] acc_max_r;
  logic [PW-1:0]                 acc_ar_r, acc_ac_r;
  logic signed [SAMPLE_BITS-1:0] base_max, new_max;
  logic [PW-1:0]                 base_ar, base_ac, new_ar, new_ac;
  logic                          ir_z, ic_z, ir_last, ic_last, row_last, col_last;
  logic                          take, emit, in_acc, in_ready, step;

  // result register
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_max_value_r;
  logic [POS_W-1:0]              out_max_row_r;
  logic [POS_W-1:0]              out_max_col_r;
  logic [POS_W-1:0]              out_row_r;
  logic [POS_W-1:0]              out_col_r;
  logic                          out_last_r;
  logic                          out_err_r;

  // ---------------- configuration ----------------
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr  = cfg_ch.valid && cfg_ch.ready;
  assign cfg_hit = cfg_wr && (cfg_ch.index == REG_IMAGE_WIDTH ||
                              cfg_ch.index == REG_IMAGE_HEIGHT ||
                              cfg_ch.index == REG_POOL_ROWS ||
                              cfg_ch.index == REG_POOL_COLS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMAGE_WIDTH_RST;
      image_height_r <= IMAGE_HEIGHT_RST;
      pool_rows_r    <= POOL_ROWS_RST;
      pool_cols_r    <= POOL_COLS_RST;
      chk_start_r    <= 1'b0;
    end else begin
      chk_start_r <= cfg_hit;
      if (cfg_wr) begin
        unique case (cfg_ch.index)
          REG_IMAGE_WIDTH:  image_width_r  <= cfg_ch.data[DIM_W-1:0];
          REG_IMAGE_HEIGHT: image_height_r <= cfg_ch.data[DIM_W-1:0];
          REG_POOL_ROWS:    pool_rows_r    <= cfg_ch.data[POOL_W-1:0];
          REG_POOL_COLS:    pool_cols_r    <= cfg_ch.data[POOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  mpa_divchk u_chk_w (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (chk_start_r),
    .dividend (image_width_r),
    .divisor  (pool_cols_r),
    .status   (chk_w_st)
  );

  mpa_divchk u_chk_h (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (chk_start_r),
    .dividend (image_height_r),
    .divisor  (pool_rows_r),
    .status   (chk_h_st)
  );

  assign chk_busy = chk_start_r || chk_w_st.busy || chk_h_st.busy;

  assign cfg_ok = (image_width_r != '0) && (image_height_r != '0) &&
                  (pool_rows_r != '0) && (pool_cols_r != '0) &&
                  (32'(image_width_r) <= MAX_WIDTH) &&
                  (32'(image_height_r) <= MAX_WIDTH) &&
                  (32'(pool_rows_r) <= MAX_POOL) &&
                  (32'(pool_cols_r) <= MAX_POOL) &&
                  chk_w_st.divisible && chk_h_st.divisible;

  // ---------------- handshake ----------------
  // an item that gives no result may pass a waiting result
  assign in_ready    = !chk_busy && (!out_valid_r || out_ch.ready || (cfg_ok && !emit));
  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;
  assign step        = in_acc && cfg_ok;

  // ---------------- window compare ----------------
  assign {rd_max, rd_ar, rd_ac} = rd_r;

  assign ir_z     = (ir_r == '0);
  assign ic_z     = (ic_r == '0);
  assign ir_last  = (POOL_W'(ir_r) == pool_rows_r - POOL_W'(1));
  assign ic_last  = (POOL_W'(ic_r) == pool_cols_r - POOL_W'(1));
  assign row_last = (cur_row_r == image_height_r - DIM_W'(1));
  assign col_last = (cur_col_r == image_width_r - DIM_W'(1));

  always_comb begin
    if (ic_z) begin
      base_max = rd_max;
      base_ar  = rd_ar;
      base_ac  = rd_ac;
    end else begin
      base_max = acc_max_r;
      base_ar  = acc_ar_r;
      base_ac  = acc_ac_r;
    end
    take = (ir_z && ic_z) || (in_ch.sample > base_max);
    if (take) begin
      new_max = in_ch.sample;
      new_ar  = ir_r;
      new_ac  = ic_r;
    end else begin
      new_max = base_max;
      new_ar  = base_ar;
      new_ac  = base_ac;
    end
  end

  assign emit    = ir_last && ic_last;
  assign mem_we  = step && ic_last;
  assign wr_data = {new_max, new_ar, new_ac};

  // ---------------- position counters ----------------
  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    r0_nxt      = r0_r;
    c0_nxt      = c0_r;
    orow_nxt    = orow_r;
    wc_nxt      = wc_r;
    ir_nxt      = ir_r;
    ic_nxt      = ic_r;
    if (cfg_hit) begin
      cur_row_nxt = '0;
      cur_col_nxt = '0;
      r0_nxt      = '0;
      c0_nxt      = '0;
      orow_nxt    = '0;
      wc_nxt      = '0;
      ir_nxt      = '0;
      ic_nxt      = '0;
    end else if (step) begin
      if (col_last) begin
        cur_col_nxt = '0;
        c0_nxt      = '0;
        wc_nxt      = '0;
        ic_nxt      = '0;
        if (row_last) begin
          cur_row_nxt = '0;
          r0_nxt      = '0;
          orow_nxt    = '0;
          ir_nxt      = '0;
        end else begin
          cur_row_nxt = cur_row_r + DIM_W'(1);
          if (ir_last) begin
            ir_nxt   = '0;
            r0_nxt   = cur_row_r + DIM_W'(1);
            orow_nxt = orow_r + DIM_W'(1);
          end else begin
            ir_nxt = ir_r + PW'(1);
          end
        end
      end else begin
        cur_col_nxt = cur_col_r + DIM_W'(1);
        if (ic_last) begin
          ic_nxt = '0;
          c0_nxt = cur_col_r + DIM_W'(1);
          wc_nxt = wc_r + AW'(1);
        end else begin
          ic_nxt = ic_r + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
      r0_r      <= '0;
      c0_r      <= '0;
      orow_r    <= '0;
      wc_r      <= '0;
      ir_r      <= '0;
      ic_r      <= '0;
    end else begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      r0_r      <= r0_nxt;
      c0_r      <= c0_nxt;
      orow_r    <= orow_nxt;
      wc_r      <= wc_nxt;
      ir_r      <= ir_nxt;
      ic_r      <= ic_nxt;
    end
  end

  // ---------------- partial maxima ----------------
  // rd_r always holds the entry for wc_r; bypass when written and read together
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wc_r] <= wr_data;
    end
    if (mem_we && (wc_nxt == wc_r)) begin
      rd_r <= wr_data;
    end else begin
      rd_r <= mem[wc_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      acc_max_r <= new_max;
      acc_ar_r  <= new_ar;
      acc_ac_r  <= new_ac;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && (!cfg_ok || emit)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !cfg_ok) begin
      out_max_value_r <= '0;
      out_max_row_r   <= '0;
      out_max_col_r   <= '0;
      out_row_r       <= '0;
      out_col_r       <= '0;
      out_last_r      <= 1'b0;
      out_err_r       <= 1'b1;
    end else if (step && emit) begin
      out_max_value_r <= new_max;
      out_max_row_r   <= POS_W'(r0_r + DIM_W'(new_ar));
      out_max_col_r   <= POS_W'(c0_r + DIM_W'(new_ac));
      out_row_r       <= POS_W'(orow_r);
      out_col_r       <= POS_W'(wc_r);
      out_last_r      <= row_last && col_last;
      out_err_r       <= 1'b0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.max_value     = out_max_value_r;
  assign out_ch.max_row       = out_max_row_r;
  assign out_ch.max_col       = out_max_col_r;
  assign out_ch.out_row       = out_row_r;
  assign out_ch.out_col       = out_col_r;
  assign out_ch.last_of_frame = out_last_r;
  assign out_ch.config_error  = out_err_r;

`ifndef ASSERT_OFF
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    chk_busy |-> !in_ch.ready)
    else $error("input accepted during configuration check");

  a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_max_value_r == '0 && out_max_row_r == '0 &&
                                    out_max_col_r == '0 && out_last_r == 1'b0))
    else $error("config error result carries data");

  a_pos_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    (!chk_busy && cfg_ok) |-> (cur_col_r < image_width_r && cur_row_r < image_height_r))
    else $error("position outside map");

  a_pos_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (!chk_busy && cfg_ok) |-> (POOL_W'(ic_r) < pool_cols_r && POOL_W'(ir_r) < pool_rows_r))
    else $error("window offset outside window");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (cur_col_r == '0 && cur_row_r == '0 && wc_r == '0))
    else $error("register write did not restart frame");
`endif

endmodule

// File: design/mpa_divchk.sv
// Bit-serial remainder unit: checks that an image dimension is a multiple of
// a window size, one dividend bit per cycle. Depends on mpa_pkg.

module mpa_divchk (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mpa_pkg::DIM_W-1:0]   dividend,
  input  logic [mpa_pkg::POOL_W-1:0]  divisor,
  output mpa_pkg::chk_status_t        status
);
  import mpa_pkg::*;

  localparam int CW = $clog2(DIM_W + 1);
  localparam int IW = $clog2(DIM_W);

  logic [POOL_W-1:0] rem_r;
  logic [POOL_W-1:0] rem_nxt;
  logic [CW-1:0]     cnt_r;
  logic              busy_r;
  logic              divisible_r;
  logic [IW-1:0]     bit_idx;
  logic [POOL_W:0]   shifted;

  assign bit_idx = IW'(cnt_r - CW'(1));
  assign shifted = {rem_r, dividend[bit_idx]};

  always_comb begin
    if (shifted >= {1'b0, divisor}) begin
      rem_nxt = POOL_W'(shifted - {1'b0, divisor});
    end else begin
      rem_nxt = POOL_W'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      divisible_r <= 1'b1;
      cnt_r       <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(DIM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r      <= 1'b0;
        divisible_r <= (rem_nxt == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
    end
  end

  assign status.busy      = busy_r;
  assign status.divisible = divisible_r;

endmodule

// File: tb/max_pool_with_argmax_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for max_pool_with_argmax: random samples under many
// map and window geometries, each result checked against an in-bench predictor.
// Depends on max_pool_with_argmax, mpa_pkg and the mpa_in_if, mpa_out_if and mpa_cfg_if interfaces.

module max_pool_with_argmax_tb;
  import mpa_pkg::*;

  localparam int LIMIT = 400000;
  localparam int MAP_MAX = MAX_WIDTH_DEF;
  localparam int WIN_MAX = MAX_POOL_DEF;

  typedef struct packed {
    logic signed [15:0] max_value;
    logic [POS_W-1:0]   max_row;
    logic [POS_W-1:0]   max_col;
    logic [POS_W-1:0]   out_row;
    logic [POS_W-1:0]   out_col;
    logic               last_of_frame;
    logic               config_error;
  } pool_res_t;

  logic clk = 1'b0;
  logic rst_n;

  mpa_in_if  in_if ();
  mpa_out_if out_if ();
  mpa_cfg_if cfg_if ();

  max_pool_with_argmax dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the block
  logic [DIM_W-1:0]   map_w, map_h;
  logic [POOL_W-1:0]  win_r, win_c;
  logic signed [15:0] run_max [MAP_MAX];
  logic [2:0]         run_arow [MAP_MAX];
  logic [2:0]         run_acol [MAP_MAX];
  int unsigned        pos_r, pos_c;

  logic signed [15:0] pending_samples[$];
  pool_res_t          expected_pools[$];
  int                 mismatches = 0;
  int                 cycles = 0;
  int                 in_gap = 0;
  int                 out_stall = 0;
  bit                 idle_en = 1'b1;

  task automatic report(input string what, input int got, input int want);
    $display("ERROR %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  function automatic bit geometry_ok();
    if (map_w == 0 || map_h == 0 || win_r == 0 || win_c == 0) return 1'b0;
    if (map_w > MAP_MAX || map_h > MAP_MAX) return 1'b0;
    if (win_r > WIN_MAX || win_c > WIN_MAX) return 1'b0;
    return (map_w % win_c == 0) && (map_h % win_r == 0);
  endfunction

  task automatic shadow_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_IMAGE_WIDTH:  map_w = val[DIM_W-1:0];
      REG_IMAGE_HEIGHT: map_h = val[DIM_W-1:0];
      REG_POOL_ROWS:    win_r = val[POOL_W-1:0];
      REG_POOL_COLS:    win_c = val[POOL_W-1:0];
      default:          return;
    endcase
    pos_r = 0;
    pos_c = 0;
  endtask

  task automatic pool_predict(input logic signed [15:0] s);
    int unsigned w, h, pr, pc, ir, ic, wc;
    pool_res_t r;
    w = map_w;
    h = map_h;
    pr = win_r;
    pc = win_c;
    r = '0;
    if (!geometry_ok()) begin
      r.config_error = 1'b1;
      expected_pools.insert(expected_pools.size(), r);
      return;
    end
    if (pos_r >= h || pos_c >= w) begin
      pos_r = 0;
      pos_c = 0;
    end
    ir = pos_r % pr;
    ic = pos_c % pc;
    wc = pos_c / pc;
    if (wc >= MAP_MAX) wc = MAP_MAX - 1;
    if (ir == 0 && ic == 0) begin
      run_max[wc] = s;
      run_arow[wc] = 3'd0;
      run_acol[wc] = 3'd0;
    end else if (s > run_max[wc]) begin
      run_max[wc] = s;
      run_arow[wc] = 3'(ir);
      run_acol[wc] = 3'(ic);
    end
    if (ir == pr - 1 && ic == pc - 1) begin
      r.max_value = run_max[wc];
      r.max_row = POS_W'(pos_r - ir + run_arow[wc]);
      r.max_col = POS_W'(pos_c - ic + run_acol[wc]);
      r.out_row = POS_W'(pos_r / pr);
      r.out_col = POS_W'(pos_c / pc);
      r.last_of_frame = (pos_r == h - 1) && (pos_c == w - 1);
      expected_pools.insert(expected_pools.size(), r);
    end
    if (pos_c + 1 >= w) begin
      pos_c = 0;
      pos_r = (pos_r + 1 >= h) ? 0 : pos_r + 1;
    end else begin
      pos_c++;
    end
  endtask

  task automatic check_pool();
    pool_res_t got, want;
    got = '{out_if.max_value, out_if.max_row, out_if.max_col, out_if.out_row,
            out_if.out_col, out_if.last_of_frame, out_if.config_error};
    if (expected_pools.size() == 0) begin
      report("result with none expected, max_value", $signed(got.max_value), 0);
      return;
    end
    want = expected_pools.pop_front();
    if (got.max_value !== want.max_value)
      report("max_value", $signed(got.max_value), $signed(want.max_value));
    if (got.max_row !== want.max_row) report("max_row", got.max_row, want.max_row);
    if (got.max_col !== want.max_col) report("max_col", got.max_col, want.max_col);
    if (got.out_row !== want.out_row) report("out_row", got.out_row, want.out_row);
    if (got.out_col !== want.out_col) report("out_col", got.out_col, want.out_col);
    if (got.last_of_frame !== want.last_of_frame)
      report("last_of_frame", got.last_of_frame, want.last_of_frame);
    if (got.config_error !== want.config_error)
      report("config_error", got.config_error, want.config_error);
  endtask

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap = 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        in_if.valid <= 1'b1;
        in_if.sample <= pending_samples.pop_front();
        if (idle_en && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 7);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // monitor: tracks accepted items and checks results
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall = 0;
      map_w = IMAGE_WIDTH_RST;
      map_h = IMAGE_HEIGHT_RST;
      win_r = POOL_ROWS_RST;
      win_c = POOL_COLS_RST;
      pos_r = 0;
      pos_c = 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) shadow_reg_write(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) pool_predict(in_if.sample);
      if (out_if.valid && out_if.ready) check_pool();
      if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (idle_en && $urandom_range(0, 9) == 0) out_stall = $urandom_range(1, 7);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2, 3:    return 16'($urandom_range(0, 6)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_samples(input int n);
    repeat (n) pending_samples.insert(pending_samples.size(), pick_sample());
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
    end while (pending_samples.size() != 0 || in_if.valid || expected_pools.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do begin
      @(posedge clk);
    end while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  // pool registers get random upper data bits, which the block ignores
  task automatic set_geometry(input int w, input int h, input int pr, input int pc);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_POOL_ROWS, {7'($urandom), 4'(pr)});
    write_reg(REG_POOL_COLS, {7'($urandom), 4'(pc)});
  endtask

  task automatic run_phase(input int w, input int h, input int pr, input int pc, input int n);
    drain();
    set_geometry(w, h, pr, pc);
    push_samples(n);
  endtask

  initial begin
    int w, h, pr, pc, n, frame, done_items, waited;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.sample = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: first row gives nothing
    push_samples(2);
    drain();

    // 4x2 map, 2x2 windows: ties, extremes, max in the top-left, top-right and bottom-right corners, frame wrap
    set_geometry(4, 2, 2, 2);
    pending_samples = '{16'sd7, 16'sd7, -16'sd32768, -16'sd32768,
                        16'sd7, 16'sd7, -16'sd32768, 16'sd32767,
                        16'sd32767, 16'sd0, -16'sd5, -16'sd2,
                        -16'sd1, 16'sd32767, -16'sd3, -16'sd4};
    drain();
    write_reg(REG_POOL_COLS, CFG_DATA_W'(3));
    push_samples(2);
    drain();
    write_reg(8'hFF, 11'h7FF);
    push_samples(2);

    // map size limits
    run_phase(1024, 1, 1, 8, 200);
    run_phase(2, 1024, 8, 2, 96);
    run_phase(1, 1, 1, 1, 10);
    run_phase(16, 8, 8, 8, 140);

    // unusable settings
    run_phase(1025, 4, 1, 1, 3);
    run_phase(4, 2047, 1, 1, 3);
    run_phase(0, 4, 1, 1, 3);
    run_phase(4, 4, 0, 2, 3);
    run_phase(8, 9, 9, 1, 3);
    run_phase(15, 8, 1, 15, 3);
    run_phase(6, 4, 2, 4, 4);

    done_items = 0;
    while (done_items < 750) begin
      pc = $urandom_range(1, 8);
      pr = $urandom_range(1, 8);
      w = pc * $urandom_range(1, 5);
      h = pr * $urandom_range(1, 3);
      frame = w * h;
      n = $urandom_range(frame / 2, 2 * frame + 1);
      if (n > 250) n = 250;
      if ($urandom_range(0, 9) == 0) begin
        if (pc > 1) w = w + $urandom_range(1, pc - 1);
        else pr = $urandom_range(9, 15);
        n = $urandom_range(3, 8);
      end
      if ($urandom_range(0, 3) == 0) begin
        run_phase(w, h, pr, pc, n / 2);
        drain();
        if ($urandom_range(0, 1) == 0) write_reg(CFG_IDX_W'($urandom_range(4, 255)), 11'($urandom));
        else write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        push_samples(n - n / 2);
      end else begin
        run_phase(w, h, pr, pc, n);
      end
      done_items += n;
    end

    drain();
    idle_en = 1'b0;
    run_phase(6, 4, 2, 3, 150);

    do begin
      @(posedge clk);
    end while (pending_samples.size() != 0 || in_if.valid);
    waited = 0;
    while (expected_pools.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (expected_pools.size() != 0) report("results never arrived", 0, expected_pools.size());
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
